// File: hw/rtl/sdjr_pkg.sv
// Shared types and constants of the strain dependent jump rate block: coefficient
// widths, fixed-point barrier coefficients, register codes and the root table builder.
// No dependencies.
`timescale 1ns / 1ps

package sdjr_pkg;

    localparam int ENERGY_FRAC_BITS_DEF = 24;
    localparam int MANTISSA_BITS_DEF    = 16;

    localparam int STRESS_W   = 21;
    localparam int ENERGY_W   = 31;
    localparam int EXPO_W     = 8;
    localparam int CFG_DATA_W = 32;
    localparam int KBT_W      = 32;
    localparam int TAU_W      = 24;
    localparam int COEF_FRAC  = 56;
    localparam int ROOT_COUNT = 24;
    localparam int ROOT_W     = 32;

    localparam logic [KBT_W-1:0] KBT_RESET = 32'd3657436;
    localparam logic [TAU_W-1:0] TAU_RESET = 24'd2830175;

    typedef enum logic {
        CFG_KBT = 1'b0,
        CFG_TAU = 1'b1
    } cfg_index_t;

    localparam int QUAD_W    = 22;
    localparam int LIN_W     = 38;
    localparam int LIN_SPLIT = 19;

    typedef logic [QUAD_W-1:0] quad_coef_t;
    typedef logic [LIN_W-1:0]  lin_coef_t;

    localparam quad_coef_t K_A0 = 22'd648518;
    localparam quad_coef_t K_A1 = 22'd432346;
    localparam quad_coef_t K_A2 = 22'd576461;
    localparam quad_coef_t K_A3 = 22'd1585267;
    localparam quad_coef_t K_A4 = 22'd2522016;
    localparam quad_coef_t K_A5 = 22'd216173;
    localparam quad_coef_t K_A6 = 22'd1224979;

    localparam lin_coef_t K_B0 = 38'd179423409154;
    localparam lin_coef_t K_B1 = 38'd175099953512;
    localparam lin_coef_t K_B2 = 38'd38190524840;
    localparam lin_coef_t K_B3 = 38'd104483511355;
    localparam lin_coef_t K_B4 = 38'd111689270759;

    localparam logic signed [63:0] K_BASE       = 64'sd58748556419122646;
    localparam logic signed [63:0] K_SHIFTED    = 64'sd59735745457442259;
    localparam logic signed [63:0] K_SHIFT_DIFF = K_SHIFTED - K_BASE;

    localparam logic signed [STRESS_W-1:0] SHEAR_LIMIT = 21'sd10800;

    typedef logic [ROOT_COUNT-1:0][ROOT_W-1:0] root_vec_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        for (int i = 0; i < 32; i++)
        begin
            b = 64'd1 << (62 - 2 * i);
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    // r_k = 2^(2^-(k+1)) in Q31
    function automatic root_vec_t build_roots();
        root_vec_t   roots;
        logic [63:0] prev;
        prev = isqrt64(64'd1 << 63);
        roots[0] = prev[ROOT_W-1:0];
        for (int k = 1; k < ROOT_COUNT; k++)
        begin
            prev = isqrt64({32'd0, roots[k-1]} << 31);
            roots[k] = prev[ROOT_W-1:0];
        end
        return roots;
    endfunction

endpackage

// File: hw/rtl/strain_dependent_jump_rate.sv
// Top level of the strain dependent jump rate block: barrier energy pipeline,
// rate exponent split and root product chain. Depends on sdjr_pkg.
//
// One stress item is taken on every cycle in which start is high; busy never rises,
// so items may follow back to back with no gap. Each item yields one result, shown
// for one cycle with done high; the receiver cannot stall and must take it then. The
// result passes through nine stages of barrier and log-rate arithmetic followed by
// 24 stages of the mantissa chain, one 32 x 32 bit multiply per stage, one stage
// per fraction bit, and an output register. The two configuration registers are
// read live, so write them only while no item is in flight.
`timescale 1ns / 1ps

module strain_dependent_jump_rate #(
    parameter int ENERGY_FRAC_BITS = sdjr_pkg::ENERGY_FRAC_BITS_DEF,
    parameter int MANTISSA_BITS    = sdjr_pkg::MANTISSA_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    output logic                                   done,
    input  logic                                   cfg_we,
    input  sdjr_pkg::cfg_index_t                   cfg_index,
    input  logic [sdjr_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic signed [sdjr_pkg::STRESS_W-1:0]   stress_first,
    input  logic signed [sdjr_pkg::STRESS_W-1:0]   stress_second,
    input  logic signed [sdjr_pkg::STRESS_W-1:0]   stress_third,
    input  logic signed [sdjr_pkg::STRESS_W-1:0]   shear_first,
    input  logic signed [sdjr_pkg::STRESS_W-1:0]   shear_second,
    output logic signed [sdjr_pkg::ENERGY_W-1:0]   barrier_energy,
    output logic signed [sdjr_pkg::EXPO_W-1:0]     rate_exponent,
    output logic [MANTISSA_BITS-1:0]               rate_mantissa,
    output logic                                   rate_saturated
);

    import sdjr_pkg::*;

    localparam int TERMS = 5;
    localparam int SH    = COEF_FRAC - ENERGY_FRAC_BITS;
    localparam int SH2   = 16 + ENERGY_FRAC_BITS;
    localparam int ACC_W = 66;
    localparam int L_W   = 65;

    localparam root_vec_t ROOTS = build_roots();

    localparam quad_coef_t K_QUAD_N   [3] = '{K_A0, K_A1, K_A2};
    localparam quad_coef_t K_QUAD_OUT [2] = '{K_A5, K_A3};
    localparam quad_coef_t K_QUAD_IN  [2] = '{K_A6, K_A4};
    localparam lin_coef_t  K_LIN  [TERMS] = '{K_B0, K_B1, K_B2, K_B4, K_B3};

    localparam logic signed [ACC_W-1:0] RND        = 66'sd1 <<< (SH - 1);
    localparam logic signed [ACC_W-1:0] ENERGY_MAX = 66'sd1073741823;
    localparam logic signed [ACC_W-1:0] ENERGY_MIN = -66'sd1073741824;
    localparam logic signed [L_W-1:0]   EXPO_MAX   = 65'sd127;
    localparam logic signed [L_W-1:0]   EXPO_MIN   = -65'sd128;
    localparam logic [ROOT_W-1:0]       X_ONE      = 32'h8000_0000;

    typedef struct packed {
        logic signed [ENERGY_W-1:0] energy;
        logic signed [EXPO_W-1:0]   expo;
        logic                       over;
        logic                       under;
        logic                       sat;
        logic [ROOT_COUNT-1:0]      frac;
    } tail_t;

    // configuration
    logic [KBT_W-1:0] kbt_reg;
    logic [TAU_W-1:0] tau_reg;

    // stage A: input capture
    logic                       a_valid_reg, a_valid_next;
    logic signed [STRESS_W-1:0] a_s_reg [TERMS];

    // stage B: squares and linear partial products
    logic                 b_valid_reg;
    logic signed [41:0]   b_sq_full [TERMS];
    logic signed [21:0]   b_lin_in  [TERMS];
    logic [40:0]          b_sq_reg [TERMS], b_sq_next [TERMS];
    logic signed [41:0]   b_lin_lo_reg [TERMS], b_lin_lo_next [TERMS];
    logic signed [41:0]   b_lin_hi_reg [TERMS], b_lin_hi_next [TERMS];
    logic [1:0]           b_outer_reg, b_outer_next;

    // stage C: quadratic partial products, linear terms
    logic                 c_valid_reg;
    quad_coef_t           c_coef [TERMS];
    logic [41:0]          c_qlo_reg [TERMS], c_qlo_next [TERMS];
    logic [42:0]          c_qhi_reg [TERMS], c_qhi_next [TERMS];
    logic signed [63:0]   c_lin_reg [TERMS], c_lin_next [TERMS];
    logic [1:0]           c_outer_reg;

    // stage D: quadratic terms
    logic                 d_valid_reg;
    logic [62:0]          d_quad_reg [TERMS], d_quad_next [TERMS];
    logic signed [63:0]   d_lin_reg [TERMS];
    logic [1:0]           d_outer_reg;

    // stage E: signed terms
    logic                 e_valid_reg;
    logic signed [63:0]   e_q [TERMS];
    logic signed [63:0]   e_term_reg [TERMS], e_term_next [TERMS];

    // stage F: partial sums
    logic                 f_valid_reg;
    logic signed [63:0]   f_part0_reg, f_part0_next;
    logic signed [63:0]   f_part1_reg, f_part1_next;

    // stage G: rounded, saturated energy
    logic                       g_valid_reg;
    logic signed [ACC_W-1:0]    g_sum, g_full;
    logic signed [ENERGY_W-1:0] g_energy_reg, g_energy_next;
    logic                       g_sat_reg, g_sat_next;

    // stage H: energy times log2(e)/kT
    logic                       h_valid_reg;
    logic signed [63:0]         h_prod_reg, h_prod_next;
    logic signed [ENERGY_W-1:0] h_energy_reg;
    logic                       h_sat_reg;

    // stage I and root chain
    logic signed [L_W-1:0] i_tau_shift, i_l, i_expo_full;
    tail_t                 i_tail_next;
    logic                  t_valid_reg [ROOT_COUNT+1];
    tail_t                 t_tail_reg  [ROOT_COUNT+1];
    logic [ROOT_W-1:0]     r_x_reg  [ROOT_COUNT];
    logic [ROOT_W-1:0]     r_x_next [ROOT_COUNT];

    // output
    tail_t                      o_tail;
    logic                       done_reg;
    logic signed [ENERGY_W-1:0] energy_reg;
    logic signed [EXPO_W-1:0]   expo_reg;
    logic [MANTISSA_BITS-1:0]   mant_reg, mant_next;
    logic                       sat_reg;

    assign busy         = 1'b0;
    assign a_valid_next = start & ~busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kbt_reg <= KBT_RESET;
            tau_reg <= TAU_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_KBT: kbt_reg <= cfg_data[KBT_W-1:0];
                CFG_TAU: tau_reg <= cfg_data[TAU_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < TERMS; i++)
        begin
            b_sq_full[i] = a_s_reg[i] * a_s_reg[i];
            b_sq_next[i] = b_sq_full[i][40:0];
            if (i < 3)
            begin
                b_lin_in[i] = 22'(a_s_reg[i]);
            end
            else
            begin
                b_lin_in[i] = (a_s_reg[i] < 0) ? -(22'(a_s_reg[i])) : 22'(a_s_reg[i]);
            end
            b_lin_lo_next[i] = b_lin_in[i] * signed'({1'b0, K_LIN[i][LIN_SPLIT-1:0]});
            b_lin_hi_next[i] = b_lin_in[i] * signed'({1'b0, K_LIN[i][LIN_W-1:LIN_SPLIT]});
        end
        for (int j = 0; j < 2; j++)
        begin
            b_outer_next[j] = (a_s_reg[3+j] < -SHEAR_LIMIT) || (a_s_reg[3+j] > SHEAR_LIMIT);
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            c_coef[i] = K_QUAD_N[i];
        end
        for (int j = 0; j < 2; j++)
        begin
            c_coef[3+j] = b_outer_reg[j] ? K_QUAD_OUT[j] : K_QUAD_IN[j];
        end
        for (int i = 0; i < TERMS; i++)
        begin
            c_qlo_next[i] = 42'(c_coef[i]) * 42'(b_sq_reg[i][19:0]);
            c_qhi_next[i] = 43'(c_coef[i]) * 43'(b_sq_reg[i][40:20]);
            c_lin_next[i] = (64'(b_lin_hi_reg[i]) <<< LIN_SPLIT) + 64'(b_lin_lo_reg[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < TERMS; i++)
        begin
            d_quad_next[i] = (63'(c_qhi_reg[i]) << 20) + 63'(c_qlo_reg[i]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < TERMS; i++)
        begin
            e_q[i] = signed'({1'b0, d_quad_reg[i]});
        end
        e_term_next[0] = d_lin_reg[0] - e_q[0];
        e_term_next[1] = e_q[1] - d_lin_reg[1];
        e_term_next[2] = -e_q[2] - d_lin_reg[2];
        for (int j = 0; j < 2; j++)
        begin
            e_term_next[3+j] = d_outer_reg[j] ? (K_SHIFT_DIFF - d_lin_reg[3+j] - e_q[3+j])
                                              : -e_q[3+j];
        end
    end

    assign f_part0_next = e_term_reg[0] + e_term_reg[1] + e_term_reg[2];
    assign f_part1_next = e_term_reg[3] + e_term_reg[4] + K_BASE;

    always_comb
    begin
        g_sum  = ACC_W'(f_part0_reg) + ACC_W'(f_part1_reg) + RND;
        g_full = g_sum >>> SH;
        priority if (g_full > ENERGY_MAX)
        begin
            g_energy_next = ENERGY_MAX[ENERGY_W-1:0];
            g_sat_next    = 1'b1;
        end
        else if (g_full < ENERGY_MIN)
        begin
            g_energy_next = ENERGY_MIN[ENERGY_W-1:0];
            g_sat_next    = 1'b1;
        end
        else
        begin
            g_energy_next = g_full[ENERGY_W-1:0];
            g_sat_next    = 1'b0;
        end
    end

    assign h_prod_next = g_energy_reg * signed'({1'b0, kbt_reg});

    always_comb
    begin
        i_tau_shift        = signed'(L_W'(tau_reg) << ENERGY_FRAC_BITS);
        i_l                = i_tau_shift - L_W'(h_prod_reg);
        i_expo_full        = i_l >>> SH2;
        i_tail_next.energy = h_energy_reg;
        i_tail_next.over   = i_expo_full > EXPO_MAX;
        i_tail_next.under  = i_expo_full < EXPO_MIN;
        i_tail_next.sat    = h_sat_reg | i_tail_next.over | i_tail_next.under;
        i_tail_next.frac   = i_l[SH2-1 -: ROOT_COUNT];
        priority if (i_tail_next.over)
        begin
            i_tail_next.expo = EXPO_MAX[EXPO_W-1:0];
        end
        else if (i_tail_next.under)
        begin
            i_tail_next.expo = EXPO_MIN[EXPO_W-1:0];
        end
        else
        begin
            i_tail_next.expo = i_expo_full[EXPO_W-1:0];
        end
    end

    for (genvar k = 0; k < ROOT_COUNT; k++)
    begin : g_root
        logic [ROOT_W-1:0]   x_in;
        logic [2*ROOT_W-1:0] prod;
        if (k == 0)
        begin : g_first
            assign x_in = X_ONE;
        end
        else
        begin : g_next
            assign x_in = r_x_reg[k-1];
        end
        assign prod        = (2*ROOT_W)'(x_in) * (2*ROOT_W)'(ROOTS[k]);
        assign r_x_next[k] = t_tail_reg[k].frac[ROOT_COUNT-1-k] ? prod[2*ROOT_W-2:ROOT_W-1]
                                                                : x_in;
    end

    assign o_tail = t_tail_reg[ROOT_COUNT];

    always_comb
    begin
        priority if (o_tail.over)
        begin
            mant_next = '1;
        end
        else if (o_tail.under)
        begin
            mant_next = '0;
        end
        else
        begin
            mant_next = r_x_reg[ROOT_COUNT-1][ROOT_W-2 -: MANTISSA_BITS];
        end
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            for (int k = 0; k <= ROOT_COUNT; k++)
            begin
                t_valid_reg[k] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg    <= a_valid_next;
            b_valid_reg    <= a_valid_reg;
            c_valid_reg    <= b_valid_reg;
            d_valid_reg    <= c_valid_reg;
            e_valid_reg    <= d_valid_reg;
            f_valid_reg    <= e_valid_reg;
            g_valid_reg    <= f_valid_reg;
            h_valid_reg    <= g_valid_reg;
            t_valid_reg[0] <= h_valid_reg;
            for (int k = 0; k < ROOT_COUNT; k++)
            begin
                t_valid_reg[k+1] <= t_valid_reg[k];
            end
            done_reg <= t_valid_reg[ROOT_COUNT];
        end
    end

    // advance payload
    always_ff @(posedge clk)
    begin
        a_s_reg[0] <= stress_first;
        a_s_reg[1] <= stress_second;
        a_s_reg[2] <= stress_third;
        a_s_reg[3] <= shear_first;
        a_s_reg[4] <= shear_second;
        for (int i = 0; i < TERMS; i++)
        begin
            b_sq_reg[i]     <= b_sq_next[i];
            b_lin_lo_reg[i] <= b_lin_lo_next[i];
            b_lin_hi_reg[i] <= b_lin_hi_next[i];
            c_qlo_reg[i]    <= c_qlo_next[i];
            c_qhi_reg[i]    <= c_qhi_next[i];
            c_lin_reg[i]    <= c_lin_next[i];
            d_quad_reg[i]   <= d_quad_next[i];
            d_lin_reg[i]    <= c_lin_reg[i];
            e_term_reg[i]   <= e_term_next[i];
        end
        b_outer_reg   <= b_outer_next;
        c_outer_reg   <= b_outer_reg;
        d_outer_reg   <= c_outer_reg;
        f_part0_reg   <= f_part0_next;
        f_part1_reg   <= f_part1_next;
        g_energy_reg  <= g_energy_next;
        g_sat_reg     <= g_sat_next;
        h_prod_reg    <= h_prod_next;
        h_energy_reg  <= g_energy_reg;
        h_sat_reg     <= g_sat_reg;
        t_tail_reg[0] <= i_tail_next;
        for (int k = 0; k < ROOT_COUNT; k++)
        begin
            t_tail_reg[k+1] <= t_tail_reg[k];
            r_x_reg[k]      <= r_x_next[k];
        end
        energy_reg <= o_tail.energy;
        expo_reg   <= o_tail.expo;
        mant_reg   <= mant_next;
        sat_reg    <= o_tail.sat;
    end

    assign done           = done_reg;
    assign barrier_energy = energy_reg;
    assign rate_exponent  = expo_reg;
    assign rate_mantissa  = mant_reg;
    assign rate_saturated = sat_reg;

endmodule
